FILE: design/bounded_priority_ready_queue_defines.svh
// Assertion macros for the priority ready queue back end (bpq_back).
// Needs clk and arst_n in the scope where a macro is used.
`ifndef BOUNDED_PRIORITY_READY_QUEUE_DEFINES_SVH
`define BOUNDED_PRIORITY_READY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define BPQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("bpq assertion failed");
`define BPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bpq assertion failed");
`else
`define BPQ_ASSERT(lbl, prop)
`define BPQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/bpq_pkg.sv
// Types, constants and helpers for the priority ready queue.
// No dependencies.
`timescale 1ns / 1ps
package bpq_pkg;
	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int LEAVES = 1 << IDX_W;
	localparam int TAG_W = 8;
	localparam int PRI_W = 8;
	localparam int OCC_W = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} bpq_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_REMOVE
	} bpq_state_t;

	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [TAG_W-1:0] tag;
	} bpq_entry_t;

	typedef struct packed {
		logic             mode;
		logic [TAG_W-1:0] process_tag;
		logic [PRI_W-1:0] priority_req;
	} bpq_in_t;

	typedef struct packed {
		logic             accepted;
		logic [TAG_W-1:0] out_tag;
		logic [PRI_W-1:0] out_priority;
		logic [OCC_W-1:0] occupancy;
		logic             is_empty;
	} bpq_out_t;

	typedef struct packed {
		bpq_op_t    op;
		bpq_entry_t entry;
	} bpq_cmd_t;

	function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] c);
		logic [CNT_W+OCC_W-1:0] w;
		w = (CNT_W + OCC_W)'(c);
		return w[OCC_W-1:0];
	endfunction
endpackage

FILE: design/bpq_front.sv
// Front end: takes requests, decodes the operation and holds them in a
// two-entry queue toward the back end. Depends on bpq_pkg.
`timescale 1ns / 1ps
module bpq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bpq_pkg::bpq_in_t  req_data,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output bpq_pkg::bpq_cmd_t cmd
);
	import bpq_pkg::*;

	bpq_cmd_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	bpq_cmd_t   cmd_in;

	assign req_ready = (fill_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = slot_q[rd_ptr_q];

	always_comb begin
		cmd_in.op        = bpq_op_t'(req_data.mode);
		cmd_in.entry.tag = req_data.process_tag;
		cmd_in.entry.pri = req_data.priority_req;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

FILE: design/bpq_argmax.sv
// Compare tree that finds the earliest entry of highest priority among the
// first count entries. Depends on bpq_pkg.
`timescale 1ns / 1ps
module bpq_argmax (
	input  bpq_pkg::bpq_entry_t [bpq_pkg::CAPACITY-1:0] entries,
	input  logic [bpq_pkg::CNT_W-1:0]                   count,
	output logic [bpq_pkg::IDX_W-1:0]                   best_idx,
	output bpq_pkg::bpq_entry_t                         best
);
	import bpq_pkg::*;

	logic             nv [IDX_W+1][LEAVES];
	bpq_entry_t       ne [IDX_W+1][LEAVES];
	logic [IDX_W-1:0] ni [IDX_W+1][LEAVES];
	logic             pick_b;

	always_comb begin
		nv = '{default: '0};
		ne = '{default: '0};
		ni = '{default: '0};
		pick_b = 1'b0;
		for (int k = 0; k < LEAVES; k++) begin
			ni[0][k] = IDX_W'(k);
			if (k < CAPACITY) begin
				nv[0][k] = (CNT_W'(k) < count);
				ne[0][k] = entries[k];
			end
		end
		for (int l = 0; l < IDX_W; l++) begin
			for (int k = 0; k < (LEAVES >> (l + 1)); k++) begin
				pick_b = nv[l][2*k+1] &&
					(!nv[l][2*k] || (ne[l][2*k+1].pri > ne[l][2*k].pri));
				nv[l+1][k] = nv[l][2*k] || nv[l][2*k+1];
				ne[l+1][k] = pick_b ? ne[l][2*k+1] : ne[l][2*k];
				ni[l+1][k] = pick_b ? ni[l][2*k+1] : ni[l][2*k];
			end
		end
	end

	assign best_idx = nv[IDX_W][0] ? ni[IDX_W][0] : '0;
	assign best     = ne[IDX_W][0];
endmodule

FILE: design/bpq_back.sv
// Back end: entry store, occupancy count, remove sequencer and response
// register. Depends on bpq_pkg, bpq_argmax and the assertion macros.
`timescale 1ns / 1ps
`include "bounded_priority_ready_queue_defines.svh"
module bpq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  bpq_pkg::bpq_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bpq_pkg::bpq_out_t rsp_data
);
	import bpq_pkg::*;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	bpq_entry_t [CAPACITY-1:0] store_q;
	logic [CNT_W-1:0]          count_q;
	bpq_state_t                state_q;
	bpq_state_t                state_d;
	logic [IDX_W-1:0]          best_q;
	bpq_entry_t                chosen_q;
	logic                      rsp_valid_q;
	bpq_out_t                  rsp_q;

	logic [IDX_W-1:0] tree_idx;
	bpq_entry_t       tree_best;
	logic             out_free;
	logic             cmd_pop;
	logic             do_insert;
	logic             do_search;
	logic             do_shift;
	logic             rsp_load;
	bpq_out_t         rsp_d;
	logic [CNT_W-1:0] count_inc;
	logic [CNT_W-1:0] count_dec;

	bpq_argmax u_argmax (
		.entries  (store_q),
		.count    (count_q),
		.best_idx (tree_idx),
		.best     (tree_best)
	);

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign count_inc = count_q + CNT_W'(1);
	assign count_dec = count_q - CNT_W'(1);
	assign cmd_ready = cmd_pop;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_free && (cmd.op == OP_REMOVE) && (count_q != '0)) begin
					state_d = ST_REMOVE;
				end
			end
			ST_REMOVE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		do_insert = 1'b0;
		do_search = 1'b0;
		do_shift  = 1'b0;
		rsp_load  = 1'b0;
		rsp_d     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_INSERT: begin
							rsp_load = 1'b1;
							if (count_q < CAP_CNT) begin
								do_insert       = 1'b1;
								rsp_d.accepted  = 1'b1;
								rsp_d.occupancy = occ_of(count_inc);
								rsp_d.is_empty  = 1'b0;
							end else begin
								rsp_d.occupancy = occ_of(count_q);
								rsp_d.is_empty  = (count_q == '0);
							end
						end
						OP_REMOVE: begin
							if (count_q == '0) begin
								rsp_load       = 1'b1;
								rsp_d.is_empty = 1'b1;
							end else begin
								do_search = 1'b1;
							end
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			ST_REMOVE: begin
				if (out_free) begin
					do_shift           = 1'b1;
					rsp_load           = 1'b1;
					rsp_d.accepted     = 1'b1;
					rsp_d.out_tag      = chosen_q.tag;
					rsp_d.out_priority = chosen_q.pri;
					rsp_d.occupancy    = occ_of(count_dec);
					rsp_d.is_empty     = (count_dec == '0);
				end
			end
			default: cmd_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			store_q[count_q[IDX_W-1:0]] <= cmd.entry;
		end
		if (do_shift) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (IDX_W'(i) >= best_q) begin
					store_q[i] <= store_q[i+1];
				end
			end
		end
		if (do_search) begin
			best_q   <= tree_idx;
			chosen_q <= tree_best;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_insert) begin
				count_q <= count_inc;
			end else if (do_shift) begin
				count_q <= count_dec;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`BPQ_ASSERT(a_count_bound, count_q <= CAP_CNT)
	`BPQ_ASSERT(a_remove_nonempty, (state_q == ST_REMOVE) |-> (count_q != '0))
	`BPQ_ASSERT_NEXT(a_remove_done, (state_q == ST_REMOVE) && out_free, (state_q == ST_IDLE) && rsp_valid_q)
	`BPQ_ASSERT_NEXT(a_insert_grows, do_insert, count_q == CNT_W'($past(count_q) + CNT_W'(1)))
endmodule

FILE: design/bounded_priority_ready_queue.sv
// Bounded priority ready queue of process entries, extract-max on remove.
// Request channel req_* carries mode, tag and priority; response channel rsp_*
// returns one response per request: accepted flag, removed tag and priority,
// occupancy and empty flag.
// An insert appends the entry when there is room, else it is dropped with
// accepted low. An insert response, or that of a remove on an empty queue, is
// registered when the back end takes its command. Throughput: inserts run at
// one per cycle while the response register is free. A remove on a non-empty
// queue registers the priority compare tree result in ST_IDLE, then in
// ST_REMOVE shifts the entry store and loads the response; no command is taken.
// A remove returns the earliest entry of highest priority and closes the gap;
// on an empty queue it returns accepted low.
// A two-entry request queue sits between the front and back ends, so requests
// keep being taken while a response waits. When the receiver holds rsp_ready
// low, the response holds, the back end stops, and req_ready drops once the
// request queue fills.
// Reset empties the queue and clears all valids; stored entries are not cleared.
// Depends on bpq_pkg, bpq_front, bpq_back.
`timescale 1ns / 1ps
module bounded_priority_ready_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bpq_pkg::bpq_in_t  req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bpq_pkg::bpq_out_t rsp_data
);
	import bpq_pkg::*;

	logic     cmd_valid;
	logic     cmd_ready;
	bpq_cmd_t cmd;

	bpq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	bpq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);
endmodule
